// ===== hw/rtl/dbf_pkg.sv =====
package dbf_pkg;

  // Lane layout: x, y, z, rx, ry, rz, slider one, slider two
  localparam int unsigned AxisCount   = 8;
  localparam int unsigned SliderFirst = 6;
  localparam int unsigned AxisW       = 16;
  localparam int unsigned CodeW       = 15;
  localparam int unsigned ButtonW     = 32;
  localparam int unsigned HatW        = 8;
  localparam int unsigned RepHatW     = 4;
  localparam int unsigned ThrW        = 16;

  localparam logic [ThrW-1:0] ThrReset = 16'd256;
  localparam logic [HatW-1:0] HatMax   = 8'd8;

  // Configuration register indexes
  localparam logic CfgThreshold = 1'b0;
  localparam logic CfgRunEnable = 1'b1;

  typedef enum logic [1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_CONNECT    = 2'd1,
    KIND_DISCONNECT = 2'd2,
    KIND_NOTIFY     = 2'd3
  } kind_e;

  typedef logic signed [AxisW-1:0] axis_t;
  typedef logic [CodeW-1:0]        code_t;

  // Control from the merging stage to every lane
  typedef struct packed {
    logic have_last;
    logic store;
    logic clear;
  } lane_ctrl_t;

  typedef struct packed {
    logic [ButtonW-1:0] buttons;
    code_t              x;
    code_t              y;
    code_t              z;
    code_t              rz;
    code_t              rx;
    code_t              ry;
    code_t              slider_one;
    code_t              slider_two;
    logic [RepHatW-1:0] hat;
  } rep_t;

endpackage

// ===== hw/rtl/dbf_if.sv =====
interface dbf_in_if;
  import dbf_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [ButtonW-1:0] buttons;
  axis_t              axis_x;
  axis_t              axis_y;
  axis_t              axis_z;
  axis_t              axis_rx;
  axis_t              axis_ry;
  axis_t              axis_rz;
  axis_t              slider_one;
  axis_t              slider_two;
  logic [HatW-1:0]    hat_code;

  modport source (
    output valid, kind, buttons, axis_x, axis_y, axis_z, axis_rx, axis_ry, axis_rz,
           slider_one, slider_two, hat_code,
    input  ready
  );

  modport sink (
    input  valid, kind, buttons, axis_x, axis_y, axis_z, axis_rx, axis_ry, axis_rz,
           slider_one, slider_two, hat_code,
    output ready
  );
endinterface

interface dbf_out_if;
  import dbf_pkg::*;

  logic               valid;
  logic               ready;
  logic [ButtonW-1:0] rep_buttons;
  code_t              rep_x;
  code_t              rep_y;
  code_t              rep_z;
  code_t              rep_rz;
  code_t              rep_rx;
  code_t              rep_ry;
  code_t              rep_slider_one;
  code_t              rep_slider_two;
  logic [RepHatW-1:0] rep_hat;

  modport source (
    output valid, rep_buttons, rep_x, rep_y, rep_z, rep_rz, rep_rx, rep_ry,
           rep_slider_one, rep_slider_two, rep_hat,
    input  ready
  );

  modport sink (
    input  valid, rep_buttons, rep_x, rep_y, rep_z, rep_rz, rep_rx, rep_ry,
           rep_slider_one, rep_slider_two, rep_hat,
    output ready
  );
endinterface

// ===== hw/rtl/gamepad_report_deadband_filter.sv =====
// Channel  Role  Beat
// in_i     sink  one sample or link event (kind, buttons, 8 axes, hat)
// out_o    src   one report (buttons, 8 axis codes, hat)
// cfg      write threshold (index 0), run enable (index 1)
//
// One beat per cycle while in_i is ready; eight lanes filter the axes and the
// merge stage decides the send in the accepting cycle; out_o is registered.
// Stored state is updated at acceptance, so each beat sees the last one's result.
// A two-entry output buffer takes reports while out_o stalls; in_i drops ready
// only when both entries are full.
// Reset clears link, send and stored state and loads the register defaults.
module gamepad_report_deadband_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dbf_in_if.sink                        in_i,
  dbf_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [dbf_pkg::ThrW-1:0]      cfg_wdata_i
);
  import dbf_pkg::*;

  logic [ThrW-1:0]      thr_q;
  logic                 run_q;
  logic                 in_ready;
  logic                 accept;
  logic                 send;
  lane_ctrl_t           ctrl;
  axis_t                axes [AxisCount];
  code_t                codes [AxisCount];
  logic [AxisCount-1:0] lane_differ;
  rep_t                 rep;
  rep_t                 rep_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
      run_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgThreshold: thr_q <= cfg_wdata_i;
        CfgRunEnable: run_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  assign axes[0] = in_i.axis_x;
  assign axes[1] = in_i.axis_y;
  assign axes[2] = in_i.axis_z;
  assign axes[3] = in_i.axis_rx;
  assign axes[4] = in_i.axis_ry;
  assign axes[5] = in_i.axis_rz;
  assign axes[6] = in_i.slider_one;
  assign axes[7] = in_i.slider_two;

  // One filter lane per axis; sliders clamp at zero
  for (genvar i = 0; i < AxisCount; i++) begin : g_lane
    dbf_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .sample_i (axes[i]),
      .clamp_i  (1'(i >= SliderFirst)),
      .thr_i    (thr_q),
      .ctrl_i   (ctrl),
      .differ_o (lane_differ[i]),
      .code_o   (codes[i])
    );
  end

  dbf_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .kind_i        (in_i.kind),
    .buttons_i     (in_i.buttons),
    .hat_i         (in_i.hat_code),
    .run_i         (run_q),
    .lane_differ_i (lane_differ),
    .send_o        (send),
    .ctrl_o        (ctrl)
  );

  // Assemble the report
  always_comb begin
    rep.buttons    = in_i.buttons;
    rep.x          = codes[0];
    rep.y          = codes[1];
    rep.z          = codes[2];
    rep.rx         = codes[3];
    rep.ry         = codes[4];
    rep.rz         = codes[5];
    rep.slider_one = codes[6];
    rep.slider_two = codes[7];
    rep.hat        = (in_i.hat_code <= HatMax) ? in_i.hat_code[RepHatW-1:0] : '0;
  end

  dbf_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (send),
    .data_i  (rep),
    .ready_o (in_ready),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (rep_out)
  );

  assign out_o.rep_buttons    = rep_out.buttons;
  assign out_o.rep_x          = rep_out.x;
  assign out_o.rep_y          = rep_out.y;
  assign out_o.rep_z          = rep_out.z;
  assign out_o.rep_rz         = rep_out.rz;
  assign out_o.rep_rx         = rep_out.rx;
  assign out_o.rep_ry         = rep_out.ry;
  assign out_o.rep_slider_one = rep_out.slider_one;
  assign out_o.rep_slider_two = rep_out.slider_two;
  assign out_o.rep_hat        = rep_out.hat;
endmodule

// ===== hw/rtl/dbf_lane.sv =====
module dbf_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dbf_pkg::axis_t                  sample_i,
  input  logic                            clamp_i,
  input  logic [dbf_pkg::ThrW-1:0]        thr_i,
  input  dbf_pkg::lane_ctrl_t             ctrl_i,
  output logic                            differ_o,
  output dbf_pkg::code_t                  code_o
);
  import dbf_pkg::*;

  axis_t              last_q;
  axis_t              last_d;
  logic signed [AxisW:0] diff;
  logic [AxisW:0]     mag;
  axis_t              pick;
  axis_t              filt;

  // Deadband against the last sent value
  always_comb begin
    diff = {sample_i[AxisW-1], sample_i} - {last_q[AxisW-1], last_q};
    mag  = diff[AxisW] ? (~diff + 1'b1) : diff;
    if (ctrl_i.have_last && (mag < {1'b0, thr_i})) begin
      pick = last_q;
    end else begin
      pick = sample_i;
    end
    filt = (clamp_i && pick[AxisW-1]) ? '0 : pick;
  end

  assign differ_o = (filt != last_q);
  // Offset to unsigned and drop the low bit
  assign code_o   = {~filt[AxisW-1], filt[AxisW-2:1]};

  // Clear on disconnect, take the filtered value on a sent report
  always_comb begin
    last_d = last_q;
    if (ctrl_i.clear) begin
      last_d = '0;
    end else if (ctrl_i.store) begin
      last_d = filt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else begin
      last_q <= last_d;
    end
  end
endmodule

// ===== hw/rtl/dbf_merge.sv =====
module dbf_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [1:0]                          kind_i,
  input  logic [dbf_pkg::ButtonW-1:0]         buttons_i,
  input  logic [dbf_pkg::HatW-1:0]            hat_i,
  input  logic                                run_i,
  input  logic [dbf_pkg::AxisCount-1:0]       lane_differ_i,
  output logic                                send_o,
  output dbf_pkg::lane_ctrl_t                 ctrl_o
);
  import dbf_pkg::*;

  kind_e              kind;
  logic               link_up_q, link_up_d;
  logic               force_q, force_d;
  logic               have_last_q, have_last_d;
  logic [ButtonW-1:0] last_buttons_q, last_buttons_d;
  logic [HatW-1:0]    last_hat_q, last_hat_d;
  logic               differ;
  logic               sample_ok;

  assign kind      = kind_e'(kind_i);
  assign differ    = (|lane_differ_i) || (buttons_i != last_buttons_q) || (hat_i != last_hat_q);
  assign sample_ok = accept_i && (kind == KIND_SAMPLE) && link_up_q && run_i;
  assign send_o    = sample_ok && (!have_last_q || force_q || differ);

  assign ctrl_o.have_last = have_last_q;
  assign ctrl_o.store     = send_o;
  assign ctrl_o.clear     = accept_i && (kind == KIND_DISCONNECT);

  // Advance link and send state on each accepted beat
  always_comb begin
    link_up_d      = link_up_q;
    force_d        = force_q;
    have_last_d    = have_last_q;
    last_buttons_d = last_buttons_q;
    last_hat_d     = last_hat_q;
    if (accept_i) begin
      unique case (kind)
        KIND_CONNECT: begin
          link_up_d = 1'b1;
          force_d   = 1'b1;
        end
        KIND_DISCONNECT: begin
          link_up_d      = 1'b0;
          have_last_d    = 1'b0;
          last_buttons_d = '0;
          last_hat_d     = '0;
        end
        KIND_NOTIFY: begin
          if (run_i) begin
            force_d = 1'b1;
          end
        end
        KIND_SAMPLE: begin
          if (send_o) begin
            have_last_d    = 1'b1;
            force_d        = 1'b0;
            last_buttons_d = buttons_i;
            last_hat_d     = hat_i;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_up_q      <= 1'b0;
      force_q        <= 1'b0;
      have_last_q    <= 1'b0;
      last_buttons_q <= '0;
      last_hat_q     <= '0;
    end else begin
      link_up_q      <= link_up_d;
      force_q        <= force_d;
      have_last_q    <= have_last_d;
      last_buttons_q <= last_buttons_d;
      last_hat_q     <= last_hat_d;
    end
  end

  // A disconnect drops the stored state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.clear |=> !have_last_q && !link_up_q)
    else $error("stored state survived a disconnect");

  // A sent report consumes the forced send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    send_o |=> have_last_q && !force_q)
    else $error("forced send still pending after a report");

  // No report without an up link and run mode on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    send_o |-> link_up_q && run_i)
    else $error("report sent with link down or run mode off");
endmodule

// ===== hw/rtl/dbf_skid.sv =====
module dbf_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dbf_pkg::rep_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          ready_i,
  output dbf_pkg::rep_t data_o
);
  import dbf_pkg::*;

  logic out_v_q;
  logic skid_v_q;
  rep_t out_q;
  rep_t skid_q;

  assign ready_o = !skid_v_q;
  assign valid_o = out_v_q;
  assign data_o  = out_q;

  // Hold a second beat while the output register is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (ready_i || !out_v_q) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= push_i;
      end
    end else if (push_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_i || !out_v_q) begin
      out_q <= skid_v_q ? skid_q : data_i;
    end else if (push_i && !skid_v_q) begin
      skid_q <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage full behind an empty output register");
endmodule

// ===== tb/gamepad_report_deadband_filter_checker.sv =====
module gamepad_report_deadband_filter_checker
  import dbf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  dbf_in_if               in_mon,
  dbf_out_if              out_mon,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [ThrW-1:0] cfg_wdata_i,
  output int              mismatch_count_o,
  output int              reports_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the registers and of the last sent report
  logic [ThrW-1:0]    threshold_q;
  logic               run_q;
  axis_t              sent_axes [AxisCount];
  logic [ButtonW-1:0] sent_buttons;
  logic [HatW-1:0]    sent_hat;
  logic               have_sent;
  logic               force_send;
  logic               link_up;

  rep_t owed_reports [$];
  int   mismatches = 0;

  // Keep the old value unless the axis has moved by at least the threshold
  function automatic axis_t apply_deadband(axis_t cand, axis_t prev);
    int moved;
    moved = int'(cand) - int'(prev);
    if (moved < 0) moved = -moved;
    return (moved >= int'(threshold_q)) ? cand : prev;
  endfunction

  function automatic code_t axis_code(axis_t v);
    int unsigned biased;
    biased = int'(v) + 32768;
    return code_t'(biased >> 1);
  endfunction

  function automatic void forget_sent();
    foreach (sent_axes[i]) sent_axes[i] = '0;
    sent_buttons = '0;
    sent_hat     = '0;
    have_sent    = 1'b0;
  endfunction

  // Advance the shadow state by one input beat, queue the report it causes
  function automatic void take_beat();
    axis_t raw  [AxisCount];
    axis_t filt [AxisCount];
    logic  differ;
    rep_t  rep;
    raw = '{in_mon.axis_x, in_mon.axis_y, in_mon.axis_z, in_mon.axis_rx,
            in_mon.axis_ry, in_mon.axis_rz, in_mon.slider_one, in_mon.slider_two};
    case (in_mon.kind)
      KIND_CONNECT: begin
        link_up    = 1'b1;
        force_send = 1'b1;
      end
      KIND_DISCONNECT: begin
        link_up = 1'b0;
        forget_sent();
      end
      KIND_NOTIFY: begin
        if (run_q) force_send = 1'b1;
      end
      default: begin
        if (link_up && run_q) begin
          for (int i = 0; i < AxisCount; i++) begin
            filt[i] = have_sent ? apply_deadband(raw[i], sent_axes[i]) : raw[i];
            if (i >= SliderFirst && filt[i] < 0) filt[i] = '0;
          end
          differ = (in_mon.buttons != sent_buttons) || (in_mon.hat_code != sent_hat);
          for (int i = 0; i < AxisCount; i++) begin
            if (filt[i] != sent_axes[i]) differ = 1'b1;
          end
          if (!have_sent || force_send || differ) begin
            rep.buttons    = in_mon.buttons;
            rep.x          = axis_code(filt[0]);
            rep.y          = axis_code(filt[1]);
            rep.z          = axis_code(filt[2]);
            rep.rx         = axis_code(filt[3]);
            rep.ry         = axis_code(filt[4]);
            rep.rz         = axis_code(filt[5]);
            rep.slider_one = axis_code(filt[6]);
            rep.slider_two = axis_code(filt[7]);
            rep.hat        = (in_mon.hat_code <= HatMax) ? in_mon.hat_code[RepHatW-1:0] : '0;
            owed_reports.push_back(rep);
            sent_axes    = filt;
            sent_buttons = in_mon.buttons;
            sent_hat     = in_mon.hat_code;
            have_sent    = 1'b1;
            force_send   = 1'b0;
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t report field %s: expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Compare an output beat with the oldest owed report
  function automatic void check_report();
    rep_t want;
    if (owed_reports.size() == 0) begin
      $display("%0t unexpected report: expected none, got buttons %0h x %0h hat %0h",
               $time, out_mon.rep_buttons, out_mon.rep_x, out_mon.rep_hat);
      mismatches++;
    end else begin
      want = owed_reports.pop_front();
      check_field("buttons", want.buttons, out_mon.rep_buttons);
      check_field("x", want.x, out_mon.rep_x);
      check_field("y", want.y, out_mon.rep_y);
      check_field("z", want.z, out_mon.rep_z);
      check_field("rz", want.rz, out_mon.rep_rz);
      check_field("rx", want.rx, out_mon.rep_rx);
      check_field("ry", want.ry, out_mon.rep_ry);
      check_field("slider_one", want.slider_one, out_mon.rep_slider_one);
      check_field("slider_two", want.slider_two, out_mon.rep_slider_two);
      check_field("hat", want.hat, out_mon.rep_hat);
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      threshold_q = ThrReset;
      run_q       = 1'b1;
      force_send  = 1'b0;
      link_up     = 1'b0;
      forget_sent();
      owed_reports.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgThreshold) threshold_q = cfg_wdata_i;
        else run_q = cfg_wdata_i[0];
      end
      if (in_mon.valid && in_mon.ready) take_beat();
      if (out_mon.valid && out_mon.ready) check_report();
    end
    mismatch_count_o <= mismatches;
    reports_owed_o   <= owed_reports.size();
  end

endmodule

// ===== tb/gamepad_report_deadband_filter_tb.sv =====
module gamepad_report_deadband_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dbf_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int PhaseItems  = 170;
  localparam int SettleGap   = 4;
  localparam int DrainCycles = 8;
  localparam int HoldAfter   = 40;
  localparam int HoldCycles  = 90;

  typedef struct {
    kind_e              kind;
    logic [ButtonW-1:0] buttons;
    axis_t              axes [AxisCount];
    logic [HatW-1:0]    hat;
  } pad_beat_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we;
  logic            cfg_idx;
  logic [ThrW-1:0] cfg_wdata;
  int              mismatch_count;
  int              reports_owed;
  int              cycle_count = 0;
  logic            steady = 1'b0;
  logic            link_seen = 1'b0;
  pad_beat_t       pad_now;

  dbf_in_if  pad_in ();
  dbf_out_if pad_out ();

  gamepad_report_deadband_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (pad_in),
    .out_o       (pad_out),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  gamepad_report_deadband_filter_checker report_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (pad_in),
    .out_mon          (pad_out),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatch_count),
    .reports_owed_o   (reports_owed)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[gamepad_report_deadband_filter] ERROR");
      $finish;
    end
  end

  // Report receiver: random stalls, one long hold-off once reports flow
  initial begin
    int hold_left;
    int taken;
    bit held;
    hold_left = 0;
    taken     = 0;
    held      = 1'b0;
    pad_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pad_out.valid && pad_out.ready) taken++;
      if (hold_left > 0) begin
        hold_left--;
        pad_out.ready <= 1'b0;
      end else if (!held && taken >= HoldAfter) begin
        held      = 1'b1;
        hold_left = HoldCycles;
        pad_out.ready <= 1'b0;
      end else begin
        pad_out.ready <= steady || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  function automatic pad_beat_t uniform_sample(logic [ButtonW-1:0] btn, axis_t level,
                                               logic [HatW-1:0] hat);
    pad_beat_t b;
    b.kind    = KIND_SAMPLE;
    b.buttons = btn;
    b.hat     = hat;
    foreach (b.axes[i]) b.axes[i] = level;
    return b;
  endfunction

  function automatic pad_beat_t scrambled_beat(kind_e k);
    pad_beat_t b;
    b.kind    = k;
    b.buttons = $urandom();
    b.hat     = HatW'($urandom_range(0, 255));
    foreach (b.axes[i]) b.axes[i] = axis_t'($urandom_range(0, 65535));
    return b;
  endfunction

  // Drift an axis: hold, nudge, jump anywhere or hit an end stop
  function automatic axis_t wander(axis_t prev);
    int v;
    v = int'(prev);
    case ($urandom_range(0, 9))
      4, 5, 6: v = v + int'($urandom_range(0, 1200)) - 600;
      7, 8:    v = int'(axis_t'($urandom_range(0, 65535)));
      9:       v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: ;
    endcase
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return axis_t'(v);
  endfunction

  // Offer one beat after a random gap and hold it until taken
  task automatic offer_beat(input pad_beat_t b);
    while (!steady && $urandom_range(0, 99) < 26) begin
      pad_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pad_in.valid      <= 1'b1;
    pad_in.kind       <= b.kind;
    pad_in.buttons    <= b.buttons;
    pad_in.axis_x     <= b.axes[0];
    pad_in.axis_y     <= b.axes[1];
    pad_in.axis_z     <= b.axes[2];
    pad_in.axis_rx    <= b.axes[3];
    pad_in.axis_ry    <= b.axes[4];
    pad_in.axis_rz    <= b.axes[5];
    pad_in.slider_one <= b.axes[6];
    pad_in.slider_two <= b.axes[7];
    pad_in.hat_code   <= b.hat;
    @(posedge clk_i);
    while (!pad_in.ready) @(posedge clk_i);
  endtask

  // Let the block drain, then write one register
  task automatic write_reg(input logic idx, input logic [ThrW-1:0] data);
    pad_in.valid <= 1'b0;
    do @(posedge clk_i); while (reports_owed != 0);
    repeat (SettleGap) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    pad_beat_t b;
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (!link_seen && pick < 30) begin
        b = scrambled_beat(KIND_CONNECT);
      end else if (pick < 4) begin
        b = scrambled_beat(KIND_CONNECT);
      end else if (pick < 7) begin
        b = scrambled_beat(KIND_DISCONNECT);
      end else if (pick < 11) begin
        b = scrambled_beat(KIND_NOTIFY);
      end else if (pick < 16) begin
        b = scrambled_beat(KIND_SAMPLE);
        pad_now = b;
      end else begin
        foreach (pad_now.axes[i]) pad_now.axes[i] = wander(pad_now.axes[i]);
        case ($urandom_range(0, 9))
          7, 8:    pad_now.buttons[$urandom_range(0, ButtonW-1)] ^= 1'b1;
          9:       pad_now.buttons = $urandom();
          default: ;
        endcase
        case ($urandom_range(0, 9))
          8:       pad_now.hat = HatW'($urandom_range(0, 8));
          9:       pad_now.hat = HatW'($urandom_range(0, 255));
          default: ;
        endcase
        b = pad_now;
      end
      if (b.kind == KIND_CONNECT) link_seen = 1'b1;
      else if (b.kind == KIND_DISCONNECT) link_seen = 1'b0;
      offer_beat(b);
    end
  endtask

  initial begin
    pad_in.valid      <= 1'b0;
    pad_in.kind       <= KIND_SAMPLE;
    pad_in.buttons    <= '0;
    pad_in.axis_x     <= '0;
    pad_in.axis_y     <= '0;
    pad_in.axis_z     <= '0;
    pad_in.axis_rx    <= '0;
    pad_in.axis_ry    <= '0;
    pad_in.axis_rz    <= '0;
    pad_in.slider_one <= '0;
    pad_in.slider_two <= '0;
    pad_in.hat_code   <= '0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CfgThreshold;
    cfg_wdata         <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Link down: sample dropped, notify still arms a forced send
    offer_beat(uniform_sample(32'hFFFF_FFFF, axis_t'(1000), 8'd3));
    offer_beat(scrambled_beat(KIND_NOTIFY));
    offer_beat(scrambled_beat(KIND_CONNECT));
    // First sample at the negative extreme, sliders clamp, hat above range
    offer_beat(uniform_sample(32'hFFFF_FFFF, axis_t'(-32768), 8'd255));
    offer_beat(uniform_sample(32'hFFFF_FFFF, axis_t'(-32768), 8'd255));
    offer_beat(uniform_sample(32'h0000_0000, axis_t'(32767), 8'd8));
    // Threshold edge: one short of it holds, exactly on it moves
    offer_beat(uniform_sample(32'h0000_0000, axis_t'(32767 - 255), 8'd8));
    offer_beat(uniform_sample(32'h0000_0000, axis_t'(32767 - 256), 8'd8));
    offer_beat(uniform_sample(32'h0000_0000, axis_t'(32767 - 256), 8'd0));
    offer_beat(scrambled_beat(KIND_NOTIFY));
    offer_beat(uniform_sample(32'h0000_0000, axis_t'(32767 - 256), 8'd0));
    offer_beat(uniform_sample(32'h0000_0000, axis_t'(32767 - 256), 8'd9));
    offer_beat(uniform_sample(32'h0000_0000, axis_t'(32767 - 256), 8'd15));
    offer_beat(uniform_sample(32'h8000_0001, axis_t'(-1), 8'd15));
    // Disconnect wipes the stored report; next sample after connect is raw
    offer_beat(scrambled_beat(KIND_DISCONNECT));
    offer_beat(uniform_sample(32'h1234_5678, axis_t'(500), 8'd4));
    offer_beat(scrambled_beat(KIND_CONNECT));
    offer_beat(uniform_sample(32'h5A5A_5A5A, axis_t'(100), 8'd1));
    offer_beat(uniform_sample(32'h5A5A_5A5A, axis_t'(150), 8'd1));
    // Zero threshold: any move goes through
    write_reg(CfgThreshold, 16'd0);
    offer_beat(uniform_sample(32'h5A5A_5A5A, axis_t'(151), 8'd1));
    offer_beat(uniform_sample(32'h5A5A_5A5A, axis_t'(151), 8'd1));
    // Largest threshold: only an end-to-end swing moves
    write_reg(CfgThreshold, 16'hFFFF);
    offer_beat(scrambled_beat(KIND_DISCONNECT));
    offer_beat(scrambled_beat(KIND_CONNECT));
    offer_beat(uniform_sample(32'h0000_0000, axis_t'(-32768), 8'd2));
    offer_beat(uniform_sample(32'h0000_0000, axis_t'(32767), 8'd2));
    // Config mode: notify ignored, samples dropped
    write_reg(CfgRunEnable, 16'd0);
    offer_beat(scrambled_beat(KIND_NOTIFY));
    offer_beat(uniform_sample(32'hA5A5_A5A5, axis_t'(0), 8'd5));
    write_reg(CfgRunEnable, 16'd1);
    offer_beat(uniform_sample(32'h0000_0000, axis_t'(32767), 8'd2));

    // Random phases over a spread of register settings
    pad_now   = uniform_sample(32'h0000_0000, axis_t'(0), 8'd0);
    link_seen = 1'b1;
    write_reg(CfgThreshold, ThrReset);
    random_phase(PhaseItems);
    write_reg(CfgThreshold, 16'd0);
    random_phase(PhaseItems);
    steady = 1'b1;
    write_reg(CfgThreshold, ThrW'($urandom_range(1, 2000)));
    random_phase(PhaseItems);
    steady = 1'b0;
    write_reg(CfgThreshold, 16'hFFFF);
    random_phase(PhaseItems);
    write_reg(CfgRunEnable, 16'd0);
    random_phase(PhaseItems / 2);
    write_reg(CfgRunEnable, 16'd1);
    write_reg(CfgThreshold, ThrW'($urandom_range(0, 1024)));
    random_phase(PhaseItems);

    // Drain and give the verdict
    pad_in.valid <= 1'b0;
    do @(posedge clk_i); while (reports_owed != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && reports_owed == 0) begin
      $display("[gamepad_report_deadband_filter] OK");
    end else begin
      $display("[gamepad_report_deadband_filter] ERROR");
    end
    $finish;
  end

endmodule
